// ----- design/half_single_float_convert_core_assert.svh -----
// Assertion macros for the half/single float converter
`ifndef HALF_SINGLE_FLOAT_CONVERT_CORE_ASSERT_SVH
`define HALF_SINGLE_FLOAT_CONVERT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HSFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define HSFC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HSFC_ASSERT_IMP(label, ante, cons, msg)
`define HSFC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- design/hsfc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared constants and opcodes for the binary16/binary32 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hsfc_pkg;
  localparam logic OP_WIDEN  = 1'b0;
  localparam logic OP_NARROW = 1'b1;
  localparam logic [31:0] S_QNAN   = 32'h7FC0_0000;
  localparam logic [31:0] S_EXPINF = 32'h7F80_0000;
  localparam logic [15:0] H_EXPINF = 16'h7C00;
  localparam logic [15:0] H_QNAN   = 16'h0200;
  localparam logic [7:0]  BIAS_DIFF = 8'd112;
endpackage
`default_nettype wire

// ----- design/hsfc_convert.sv -----
// ----------------------------------------------------------------------------
// hsfc_convert
// Combinational conversion between binary16 and binary32 bit patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hsfc_convert import hsfc_pkg::*; (
  input  wire logic        opcode,
  input  wire logic [31:0] operand_bits,
  output logic      [31:0] result_bits
);
  logic [31:0] wide;
  logic [15:0] narrow;
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [7:0]  se;
  logic [3:0]  lz;
  logic [9:0]  nm;
  logic [7:0]  ne;

  always_comb begin
    he = operand_bits[14:10];
    hm = operand_bits[9:0];
    // leading-zero count over the 10-bit subnormal mantissa
    lz = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (hm[i]) lz = 4'(9 - i);
    end
    nm = 10'(hm << (lz + 4'd1));
    ne = 8'd113 - 8'(lz) - 8'd1;
    if (he == 5'd0) begin
      if (hm == 10'd0) wide = {operand_bits[15], 31'd0};
      else wide = {operand_bits[15], ne, nm, 13'd0};
    end else if (he == 5'h1F) begin
      wide = {operand_bits[15], 31'd0} | ((hm != 10'd0) ? S_QNAN : S_EXPINF);
    end else begin
      wide = {operand_bits[15], 8'({3'd0, he} + BIAS_DIFF), hm, 13'd0};
    end

    se = operand_bits[30:23];
    if (se == 8'hFF) begin
      narrow = {operand_bits[31], 15'd0} | H_EXPINF
             | ((operand_bits[22:0] != 23'd0) ? H_QNAN : 16'd0);
    end else if (se <= BIAS_DIFF) begin
      narrow = {operand_bits[31], 15'd0};
    end else if (se >= 8'd143) begin
      narrow = {operand_bits[31], 15'd0} | H_EXPINF;
    end else begin
      narrow = {operand_bits[31], 5'(se - BIAS_DIFF), operand_bits[22:13]};
    end

    result_bits = (opcode == OP_NARROW) ? {16'd0, narrow} : wide;
  end
endmodule
`default_nettype wire

// ----- design/half_single_float_convert_core.sv -----
// ----------------------------------------------------------------------------
// half_single_float_convert_core
// IEEE binary16 <-> binary32 converter, one transaction per cycle.
// ----------------------------------------------------------------------------
// A transaction is taken whenever start is high (busy is always low); its
// result passes through the input register and then the result register and
// appears on out_result_bits with out_valid, for one cycle only. The receiver
// cannot stall, so every result must be captured when out_valid is high.
`timescale 1ns / 1ps
`default_nettype none
`include "half_single_float_convert_core_assert.svh"
module half_single_float_convert_core import hsfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_operand_bits,
  output logic             out_valid,
  output logic      [31:0] out_result_bits
);
  logic        vld_r, res_vld_r;
  logic        op_r;
  logic [31:0] opnd_r, res_r, res_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      vld_r     <= start;
      res_vld_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= in_opcode;
    opnd_r <= in_operand_bits;
    res_r  <= res_nxt;
  end

  hsfc_convert u_conv (
    .opcode       (op_r),
    .operand_bits (opnd_r),
    .result_bits  (res_nxt)
  );

  assign out_valid       = res_vld_r;
  assign out_result_bits = res_r;

  `HSFC_ASSERT_NXT(a_pipe_valid, start, vld_r, "accepted transaction lost")
  `HSFC_ASSERT_NXT(a_res_valid, vld_r, out_valid, "result strobe missing")
  `HSFC_ASSERT_NXT(a_narrow_upper, vld_r && op_r == OP_NARROW,
                   out_result_bits[31:16] == 16'd0, "binary16 upper bits set")
  `HSFC_ASSERT_IMP(a_no_busy, 1'b1, !busy, "busy raised")
endmodule
`default_nettype wire
